@@ rtl/cmr_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the CAN multi-frame reassembler.
// No dependencies; used by cmr_seq and the top level.
package cmr_pkg;

  localparam int BUFFER_BYTES = 64;
  localparam int BUF_AW       = $clog2(BUFFER_BYTES);
  localparam int LEN_W        = 7;
  localparam int CNT_W        = 4;
  localparam int WORD_BYTES   = 8;

  localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(WORD_BYTES);

  localparam logic [1:0] STAT_NOT_ADDR = 2'd0;
  localparam logic [1:0] STAT_MISMATCH = 2'd1;
  localparam logic [1:0] STAT_MORE     = 2'd2;
  localparam logic [1:0] STAT_COMPLETE = 2'd3;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_FINISH,
    S_OUT,
    S_READ
  } state_t;

  typedef struct packed {
    logic              kind;
    logic [1:0]        status;
    logic              is_response;
    logic [1:0]        priority_res;
    logic [3:0]        source;
    logic [8:0]        command;
    logic [7:0]        chunk_index;
    logic [LEN_W-1:0]  message_length;
    logic              overflow;
    logic [63:0]       data_word;
    logic [3:0]        word_bytes;
    logic              last;
  } out_t;

  typedef struct packed {
    logic              we;
    logic [BUF_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [BUF_AW-1:0] raddr;
  } ram_req_t;

endpackage

@@ rtl/cmr_in_if.sv @@
`timescale 1ns / 1ps
// Frame input channel: valid/ready handshake with the received frame fields.
// Standalone; no package dependency.
interface cmr_in_if;
  logic        valid;
  logic        ready;
  logic [28:0] frame_id;
  logic [3:0]  byte_count;
  logic [63:0] payload;

  modport src (output valid, frame_id, byte_count, payload, input ready);
  modport snk (input valid, frame_id, byte_count, payload, output ready);
endinterface

@@ rtl/cmr_out_if.sv @@
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with status and message word fields.
// Standalone; no package dependency.
interface cmr_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [1:0]  status;
  logic        is_response;
  logic [1:0]  priority_res;
  logic [3:0]  source;
  logic [8:0]  command;
  logic [7:0]  chunk_index;
  logic [6:0]  message_length;
  logic        overflow;
  logic [63:0] data_word;
  logic [3:0]  word_bytes;
  logic        last;

  modport src (output valid, kind, status, is_response, priority_res, source, command,
               chunk_index, message_length, overflow, data_word, word_bytes, last,
               input ready);
  modport snk (input valid, kind, status, is_response, priority_res, source, command,
               chunk_index, message_length, overflow, data_word, word_bytes, last,
               output ready);
endinterface

@@ rtl/cmr_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module cmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/cmr_seq.sv @@
`timescale 1ns / 1ps
// Frame sequencer: decode, append bytes into the buffer RAM, result register and readout.
// Depends on cmr_pkg, cmr_in_if, cmr_out_if.
module cmr_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [3:0]        own_address,
  cmr_in_if.snk             in_beat,
  cmr_out_if.src            out_beat,
  output cmr_pkg::ram_req_t ram_req,
  input  logic [7:0]        ram_rdata
);

  localparam int LW = cmr_pkg::LEN_W;
  localparam int CW = cmr_pkg::CNT_W;

  cmr_pkg::state_t state_r, state_nxt, ret_r, ret_nxt;
  logic            busy_r, busy_nxt;
  logic [8:0]      act_cmd_r, act_cmd_nxt;
  logic [LW-1:0]   fill_r, fill_nxt;
  logic            ovf_r, ovf_nxt;
  logic            out_valid_r, out_valid_nxt;
  cmr_pkg::out_t   out_r, out_nxt;
  cmr_pkg::out_t   hdr_r, hdr_nxt;
  logic            lastf_r, lastf_nxt;
  logic [63:0]     pay_r, pay_nxt;
  logic [CW-1:0]   nwr_r, nwr_nxt;
  logic [CW-1:0]   lane_r, lane_nxt;
  logic            pend_r, pend_nxt;
  logic [2:0]      pend_lane_r, pend_lane_nxt;
  logic [LW-1:0]   wbase_r, wbase_nxt;
  logic [CW-1:0]   nb_r, nb_nxt;
  logic [LW-1:0]   msg_len_r, msg_len_nxt;
  logic [63:0]     word_r, word_nxt;

  logic [28:0]     id;
  logic [CW-1:0]   cnt;
  logic [LW-1:0]   room;
  logic            cut;
  logic [LW-1:0]   rd_addr;
  logic [LW-1:0]   wbase_next;
  logic [LW-1:0]   remain;
  logic [63:0]     word_upd;
  logic            word_last;

  assign id   = in_beat.frame_id;
  assign cnt  = (in_beat.byte_count > cmr_pkg::MAX_COUNT) ? cmr_pkg::MAX_COUNT
                                                          : in_beat.byte_count;
  assign room = LW'(cmr_pkg::BUFFER_BYTES) - fill_r;
  assign cut  = LW'(cnt) > room;

  assign rd_addr    = wbase_r + LW'(lane_r);
  assign wbase_next = wbase_r + LW'(cmr_pkg::WORD_BYTES);
  assign remain     = msg_len_r - wbase_next;
  assign word_last  = wbase_next >= msg_len_r;

  always_comb begin
    word_upd = word_r;
    word_upd[pend_lane_r*8 +: 8] = ram_rdata;
  end

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    busy_nxt      = busy_r;
    act_cmd_nxt   = act_cmd_r;
    fill_nxt      = fill_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    hdr_nxt       = hdr_r;
    lastf_nxt     = lastf_r;
    pay_nxt       = pay_r;
    nwr_nxt       = nwr_r;
    lane_nxt      = lane_r;
    pend_nxt      = 1'b0;
    pend_lane_nxt = pend_lane_r;
    wbase_nxt     = wbase_r;
    nb_nxt        = nb_r;
    msg_len_nxt   = msg_len_r;
    word_nxt      = word_r;
    ram_req       = '0;
    in_beat.ready = 1'b0;

    case (state_r)
      cmr_pkg::S_IDLE: begin
        in_beat.ready = 1'b1;
        if (in_beat.valid) begin
          hdr_nxt              = '0;
          hdr_nxt.kind         = cmr_pkg::KIND_STATUS;
          hdr_nxt.priority_res = id[28:27];
          hdr_nxt.is_response  = id[26];
          hdr_nxt.command      = id[25:17];
          hdr_nxt.chunk_index  = id[15:8];
          hdr_nxt.source       = id[3:0];
          hdr_nxt.last         = 1'b1;
          lastf_nxt            = id[16];
          pay_nxt              = in_beat.payload;
          if (id[7:4] != own_address) begin
            out_nxt        = '0;
            out_nxt.status = cmr_pkg::STAT_NOT_ADDR;
            out_nxt.last   = 1'b1;
            out_valid_nxt  = 1'b1;
            ret_nxt        = cmr_pkg::S_IDLE;
            state_nxt      = cmr_pkg::S_OUT;
          end else if (busy_r && (id[25:17] != act_cmd_r)) begin
            out_nxt        = hdr_nxt;
            out_nxt.status = cmr_pkg::STAT_MISMATCH;
            out_valid_nxt  = 1'b1;
            ret_nxt        = cmr_pkg::S_IDLE;
            state_nxt      = cmr_pkg::S_OUT;
          end else begin
            busy_nxt    = 1'b1;
            act_cmd_nxt = id[25:17];
            ovf_nxt     = ovf_r | cut;
            nwr_nxt     = cut ? room[CW-1:0] : cnt;
            lane_nxt    = '0;
            state_nxt   = (nwr_nxt == '0) ? cmr_pkg::S_FINISH : cmr_pkg::S_WRITE;
          end
        end
      end

      cmr_pkg::S_WRITE: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = fill_r[cmr_pkg::BUF_AW-1:0];
        ram_req.wdata = pay_r[lane_r[2:0]*8 +: 8];
        fill_nxt      = fill_r + LW'(1);
        lane_nxt      = lane_r + CW'(1);
        if (lane_nxt == nwr_r) begin
          state_nxt = cmr_pkg::S_FINISH;
        end
      end

      cmr_pkg::S_FINISH: begin
        out_nxt          = hdr_r;
        out_nxt.overflow = ovf_r;
        out_valid_nxt    = 1'b1;
        state_nxt        = cmr_pkg::S_OUT;
        if (!lastf_r) begin
          out_nxt.status = cmr_pkg::STAT_MORE;
          ret_nxt        = cmr_pkg::S_IDLE;
        end else begin
          out_nxt.status         = cmr_pkg::STAT_COMPLETE;
          out_nxt.message_length = fill_r;
          out_nxt.last           = (fill_r == '0);
          ret_nxt      = (fill_r == '0) ? cmr_pkg::S_IDLE : cmr_pkg::S_READ;
          msg_len_nxt  = fill_r;
          busy_nxt     = 1'b0;
          fill_nxt     = '0;
          ovf_nxt      = 1'b0;
          wbase_nxt    = '0;
          lane_nxt     = '0;
          word_nxt     = '0;
          nb_nxt       = (fill_r > LW'(cmr_pkg::WORD_BYTES)) ? cmr_pkg::MAX_COUNT
                                                             : fill_r[CW-1:0];
        end
      end

      cmr_pkg::S_OUT: begin
        if (out_beat.ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = ret_r;
        end
      end

      cmr_pkg::S_READ: begin
        if (lane_r < nb_r) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = rd_addr[cmr_pkg::BUF_AW-1:0];
          lane_nxt      = lane_r + CW'(1);
          pend_nxt      = 1'b1;
          pend_lane_nxt = lane_r[2:0];
        end
        if (pend_r) begin
          word_nxt = word_upd;
          if (CW'(pend_lane_r) == nb_r - CW'(1)) begin
            out_nxt            = '0;
            out_nxt.kind       = cmr_pkg::KIND_DATA;
            out_nxt.data_word  = word_upd;
            out_nxt.word_bytes = nb_r;
            out_nxt.last       = word_last;
            out_valid_nxt      = 1'b1;
            ret_nxt            = word_last ? cmr_pkg::S_IDLE : cmr_pkg::S_READ;
            state_nxt          = cmr_pkg::S_OUT;
            wbase_nxt          = wbase_next;
            lane_nxt           = '0;
            word_nxt           = '0;
            nb_nxt = (remain > LW'(cmr_pkg::WORD_BYTES)) ? cmr_pkg::MAX_COUNT
                                                         : remain[CW-1:0];
          end
        end
      end

      default: begin
        state_nxt = cmr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cmr_pkg::S_IDLE;
      ret_r       <= cmr_pkg::S_IDLE;
      busy_r      <= 1'b0;
      act_cmd_r   <= '0;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      busy_r      <= busy_nxt;
      act_cmd_r   <= act_cmd_nxt;
      fill_r      <= fill_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r       <= out_nxt;
    hdr_r       <= hdr_nxt;
    lastf_r     <= lastf_nxt;
    pay_r       <= pay_nxt;
    nwr_r       <= nwr_nxt;
    lane_r      <= lane_nxt;
    pend_lane_r <= pend_lane_nxt;
    wbase_r     <= wbase_nxt;
    nb_r        <= nb_nxt;
    msg_len_r   <= msg_len_nxt;
    word_r      <= word_nxt;
  end

  assign out_beat.valid          = out_valid_r;
  assign out_beat.kind           = out_r.kind;
  assign out_beat.status         = out_r.status;
  assign out_beat.is_response    = out_r.is_response;
  assign out_beat.priority_res   = out_r.priority_res;
  assign out_beat.source         = out_r.source;
  assign out_beat.command        = out_r.command;
  assign out_beat.chunk_index    = out_r.chunk_index;
  assign out_beat.message_length = out_r.message_length;
  assign out_beat.overflow       = out_r.overflow;
  assign out_beat.data_word      = out_r.data_word;
  assign out_beat.word_bytes     = out_r.word_bytes;
  assign out_beat.last           = out_r.last;

endmodule

@@ rtl/can_multiframe_reassembler.sv @@
`timescale 1ns / 1ps
// Top level: address register, frame sequencer and message byte buffer RAM.
// Depends on cmr_pkg, cmr_in_if, cmr_out_if, cmr_ram, cmr_seq.
//
//   port      dir   flow control     beat
//   in_beat   in    valid/ready      one received frame
//   out_beat  out   valid/ready      one status result or one message word
//   cfg_*     in    write enable     own_address, 4 bits
//
// A frame that is not addressed here or has the wrong command has its status result
// registered on acceptance, then waits for the output handshake. An appended frame
// stores n bytes, one byte per cycle into the buffer RAM, then registers its result
// for the output handshake. On completion each message word takes word_bytes RAM
// reads plus its handshake. One frame at a time; a stalled result holds the block.
// Reset is synchronous, active low; no clearing pass.
module can_multiframe_reassembler (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   cfg_wr_en,
  input  logic [3:0] cfg_wr_data,
  cmr_in_if.snk  in_beat,
  cmr_out_if.src out_beat
);

  logic [3:0]        own_address_r;
  cmr_pkg::ram_req_t ram_req;
  logic [7:0]        ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_address_r <= '0;
    end else if (cfg_wr_en) begin
      own_address_r <= cfg_wr_data;
    end
  end

  cmr_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .own_address (own_address_r),
    .in_beat     (in_beat),
    .out_beat    (out_beat),
    .ram_req     (ram_req),
    .ram_rdata   (ram_rdata)
  );

  cmr_ram #(
    .WIDTH (8),
    .DEPTH (cmr_pkg::BUFFER_BYTES)
  ) u_buf (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  a_in_no_pending_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat.valid && in_beat.ready) |-> !out_beat.valid)
    else $error("frame accepted while a result is pending");

  a_ram_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.we |-> !ram_req.re)
    else $error("buffer write and read in the same cycle");

  a_data_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_beat.valid && out_beat.kind == cmr_pkg::KIND_DATA) |->
      (out_beat.word_bytes != 4'd0 && out_beat.word_bytes <= cmr_pkg::MAX_COUNT))
    else $error("message word with bad byte count");

  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_beat.valid && out_beat.kind == cmr_pkg::KIND_STATUS) |->
      (out_beat.data_word == 64'd0 && out_beat.word_bytes == 4'd0))
    else $error("status result carries data");

endmodule
